// ----- design/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation block: the controller states
// and the status that the modular multiplier reports to the controller.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE_WAIT,
        ST_SCAN,
        ST_MULT_WAIT,
        ST_SQUARE_WAIT,
        ST_DONE
    } mexp_state_t;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_stat_t;

endpackage

// ----- design/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier. It forms (a * b) mod m by shift and add,
// taking one bit of b per cycle from the most significant end, and keeps the
// accumulator below m at every step.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [OPERAND_WIDTH-1:0]   op_a,
    input  logic [OPERAND_WIDTH-1:0]   op_b,
    input  logic [OPERAND_WIDTH-1:0]   modulus,
    output mexp_pkg::mexp_mul_stat_t   stat,
    output logic [OPERAND_WIDTH-1:0]   product
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [W+1:0]   sum;
    logic [W+1:0]   sum_less_m;
    logic [W+1:0]   sum_less_2m;
    logic [W+1:0]   m_ext;
    logic [W+1:0]   m2_ext;

    // One step: acc = (2 * acc + bit * a) mod m. The sum stays below 3m,
    // so one of three candidates is the reduced value.
    always_comb begin
        m_ext       = {2'b00, modulus};
        m2_ext      = {1'b0, modulus, 1'b0};
        sum         = {1'b0, acc_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        sum_less_m  = sum - m_ext;
        sum_less_2m = sum - m2_ext;
        if (sum >= m2_ext) begin
            acc_next = sum_less_2m[W-1:0];
        end else if (sum >= m_ext) begin
            acc_next = sum_less_m[W-1:0];
        end else begin
            acc_next = sum[W-1:0];
        end
    end

    // Control: a run of W steps, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: operands are captured at start, the multiplier shifts out.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ----- design/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ^ exponent mod modulus by right-to-left square and multiply
// on one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage: a request on the s_ channel carries base, exponent and modulus; the
// m_ channel returns one result per request, the power and an error flag.
// Both channels use valid and ready. A zero modulus returns zero with the
// error flag set; the request goes straight to the done state, without the
// multiplier. Otherwise the base is first reduced by the multiplier, then
// each exponent bit takes a scan state, a squaring and, for a set bit, a
// multiplication; the squaring after the highest set bit is skipped and
// scanning stops there.
// The run time is set by the multiplier, which consumes one bit per cycle.
// One request is processed at a time. A finished result waits in an output
// register, so the next request is accepted while the receiver stalls; its
// result is held back until the earlier one is taken.
// Reset clears the controller and the output valid; a request in progress
// is dropped.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_base_value,
    input  logic [31:0] s_exponent_value,
    input  logic [31:0] s_modulus_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_power_result,
    output logic        m_zero_modulus_error
);
    import mexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    mexp_state_t    state_reg, state_next;
    mexp_mul_stat_t mul_stat;

    logic [W-1:0]   base_reg;
    logic [W-1:0]   expo_reg;
    logic [W-1:0]   mod_reg;
    logic [W-1:0]   res_reg;
    logic           err_reg;

    logic [W-1:0]   base_in;
    logic [W-1:0]   expo_in;
    logic [W-1:0]   mod_in;

    logic           mul_start;
    logic [W-1:0]   mul_a;
    logic [W-1:0]   mul_b;
    logic [W-1:0]   mul_product;

    logic           accept;
    logic           out_load;
    logic           out_valid_reg;
    logic [31:0]    pow_out_reg;
    logic           err_out_reg;

    // Inputs are sized to the datapath width.
    assign base_in = W'(s_base_value);
    assign expo_in = W'(s_exponent_value);
    assign mod_in  = W'(s_modulus_value);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (mod_in == '0) ? ST_DONE : ST_REDUCE_WAIT;
                end
            end
            ST_REDUCE_WAIT: begin
                if (mul_stat.done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (expo_reg == '0) begin
                    state_next = ST_DONE;
                end else if (expo_reg[0]) begin
                    state_next = ST_MULT_WAIT;
                end else begin
                    state_next = ST_SQUARE_WAIT;
                end
            end
            ST_MULT_WAIT: begin
                if (mul_stat.done) begin
                    // No further set bits: the last squaring is not needed.
                    state_next = (expo_reg[W-1:1] == '0) ? ST_DONE : ST_SQUARE_WAIT;
                end
            end
            ST_SQUARE_WAIT: begin
                if (mul_stat.done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Multiplier requests: reduction as 1 * base, then multiply or square.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = base_reg;
        mul_b     = base_reg;
        case (state_reg)
            ST_IDLE: begin
                mul_start = accept && (mod_in != '0);
                mul_a     = W'(1);
                mul_b     = base_in;
            end
            ST_SCAN: begin
                mul_start = (expo_reg != '0);
                mul_a     = expo_reg[0] ? res_reg : base_reg;
            end
            ST_MULT_WAIT: begin
                mul_start = mul_stat.done && (expo_reg[W-1:1] != '0);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            expo_reg <= expo_in;
            mod_reg  <= mod_in;
            res_reg  <= (mod_in == '0) ? '0 : W'(1);
            err_reg  <= (mod_in == '0);
        end else if (mul_stat.done) begin
            case (state_reg)
                ST_REDUCE_WAIT: base_reg <= mul_product;
                ST_MULT_WAIT:   res_reg  <= mul_product;
                ST_SQUARE_WAIT: begin
                    base_reg <= mul_product;
                    expo_reg <= {1'b0, expo_reg[W-1:1]};
                end
                default: begin
                end
            endcase
        end
    end

    // Output register parts the result channel from the controller.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pow_out_reg <= 32'(res_reg);
            err_out_reg <= err_reg;
        end
    end

    mexp_mulmod #(
        .OPERAND_WIDTH (W)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    assign m_valid              = out_valid_reg;
    assign m_power_result       = pow_out_reg;
    assign m_zero_modulus_error = err_out_reg;

    // A new multiplication is never requested while one is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    // A finished multiplication is only reported while the controller waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == ST_REDUCE_WAIT || state_reg == ST_MULT_WAIT ||
                           state_reg == ST_SQUARE_WAIT))
        else $error("multiplier result arrived outside a wait state");

    // A zero-modulus result always carries a zero power.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_modulus_error) |-> (m_power_result == 32'd0))
        else $error("error result with nonzero power");

    // Requests are only taken when the controller is free, and each one taken starts processing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DONE || state_reg == ST_REDUCE_WAIT))
        else $error("accepted request did not start processing");

endmodule
